// File: rtl/pidm_pkg.sv
// ----------------------------------------------------------------------------
// PWM input duty meter package
// Shared constants, action codes and item types of the duty meter.
// ----------------------------------------------------------------------------
package pidm_pkg;

    localparam int CAPTURE_BITS       = 16;
    localparam int DUTY_FRACTION_BITS = 12;
    localparam int DUTY_BITS          = DUTY_FRACTION_BITS + 1;
    localparam int STEP_BITS          = $clog2(DUTY_BITS);
    localparam int COUNT_BITS         = 8;
    localparam int WRONG_BITS         = 16;

    localparam logic [1:0] ACT_RISE = 2'd0;
    localparam logic [1:0] ACT_FALL = 2'd1;
    localparam logic [1:0] ACT_OVF  = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [WRONG_BITS-1:0] WRONG_MAX   = {WRONG_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] LIMIT_RESET = 8'd10;

    typedef struct packed {
        logic [1:0]              action;
        logic [CAPTURE_BITS-1:0] period_capture;
        logic [CAPTURE_BITS-1:0] high_capture;
    } item_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0]  duty;
        logic                  no_signal;
        logic                  math_error;
        logic [WRONG_BITS-1:0] wrong_count;
    } result_t;

endpackage

// File: rtl/pidm_divider.sv
// ----------------------------------------------------------------------------
// PWM input duty meter divider
// Restoring divider giving floor(high * 2^DUTY_FRACTION_BITS / period), one
// quotient bit per cycle. The operands must satisfy high <= period, period > 0.
// ----------------------------------------------------------------------------
module pidm_divider
    import pidm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [CAPTURE_BITS-1:0] dividend,
    input  logic [CAPTURE_BITS-1:0] divisor,
    output logic                    done,
    output logic [DUTY_BITS-1:0]    quotient
);

    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DUTY_FRACTION_BITS);

    logic                    busy_reg;
    logic                    done_reg;
    logic [STEP_BITS-1:0]    step_reg;
    logic [CAPTURE_BITS:0]   rem_reg;
    logic [CAPTURE_BITS-1:0] div_reg;
    logic [DUTY_BITS-1:0]    quot_reg;

    logic [CAPTURE_BITS:0]   trial;
    logic                    fits;

    always_comb
    begin
        if (step_reg == '0)
        begin
            trial = rem_reg;
        end
        else
        begin
            trial = {rem_reg[CAPTURE_BITS-1:0], 1'b0};
        end
        fits = (trial >= {1'b0, div_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, dividend};
            div_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? (trial - {1'b0, div_reg}) : trial;
            quot_reg <= {quot_reg[DUTY_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// File: rtl/pwm_input_duty_meter_top.sv
// ----------------------------------------------------------------------------
// PWM input duty meter
// Keeps the duty cycle, lost-signal flag and error statistics of a PWM input
// from rising-edge, falling-edge and timer-overflow capture items.
// ----------------------------------------------------------------------------
// Usage: each capture item enters on the item channel (valid/ready) and gives
// exactly one result item on the result channel, showing the state after it.
// An item that needs a new duty value passes through a shared restoring
// divider producing one quotient bit per cycle, then through the done state
// into the output register; other items go from acceptance straight to the
// done state. The input is not ready while an item is being worked on. The
// result sits in an output register, so the next item is accepted while a
// result waits; if the receiver stalls, the following item is held finished
// until the register is free. The user must write the no-signal limit
// through cfg_we and cfg_wdata only while the block is idle; the block does
// not enforce this. Reset clears all statistics, sets the limit to ten and
// arms the first-rising-edge handling; no result is pending after reset.
// ----------------------------------------------------------------------------
module pwm_input_duty_meter_top
    import pidm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item_data,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result_data,
    input  logic                  cfg_we,
    input  logic [COUNT_BITS-1:0] cfg_wdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIVIDE = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    item_t                 item_reg;
    logic [COUNT_BITS-1:0] limit_reg;
    logic                  first_reg;
    logic [DUTY_BITS-1:0]  duty_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  lost_reg;
    logic                  error_reg;
    logic [WRONG_BITS-1:0] wrong_reg;
    logic                  out_valid_reg;
    result_t               out_reg;

    logic                  first_next;
    logic [DUTY_BITS-1:0]  duty_next;
    logic [COUNT_BITS-1:0] count_next;
    logic                  lost_next;
    logic                  error_next;
    logic [WRONG_BITS-1:0] wrong_next;

    logic                  accept;
    logic                  commit;
    logic                  need_div;
    logic                  in_high_gt;
    logic                  in_zero;
    logic                  high_gt;
    logic                  period_zero;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  div_done;
    logic [DUTY_BITS-1:0]  quotient;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign commit     = (state_reg == ST_DONE) && (!out_valid_reg || result_ready);

    assign in_high_gt = (item_data.high_capture > item_data.period_capture);
    assign in_zero    = (item_data.period_capture == '0);
    assign need_div   = !in_high_gt && !in_zero &&
                        ((item_data.action == ACT_OVF) ||
                         ((item_data.action == ACT_RISE) && !first_reg));

    pidm_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && need_div),
        .dividend (item_data.high_capture),
        .divisor  (item_data.period_capture),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = need_div ? ST_DIVIDE : ST_DONE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        high_gt     = (item_reg.high_capture > item_reg.period_capture);
        period_zero = (item_reg.period_capture == '0);
        count_inc   = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        first_next  = first_reg;
        duty_next   = duty_reg;
        count_next  = count_reg;
        lost_next   = lost_reg;
        error_next  = error_reg;
        wrong_next  = wrong_reg;
        case (item_reg.action)
            ACT_RISE:
            begin
                if (first_reg)
                begin
                    first_next = 1'b0;
                    duty_next  = '0;
                end
                else
                begin
                    count_next = '0;
                    if (high_gt)
                    begin
                        error_next = 1'b1;
                        if (wrong_reg != WRONG_MAX)
                        begin
                            wrong_next = wrong_reg + 1'b1;
                        end
                    end
                    else if (period_zero)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        duty_next = quotient;
                    end
                end
            end
            ACT_OVF:
            begin
                count_next = count_inc;
                if (high_gt)
                begin
                    duty_next  = '0;
                    error_next = 1'b1;
                end
                else if (!period_zero)
                begin
                    duty_next = quotient;
                end
                if (count_inc > limit_reg)
                begin
                    duty_next = '0;
                    lost_next = 1'b1;
                end
                else if (count_inc < limit_reg)
                begin
                    lost_next = 1'b0;
                end
            end
            default:
            begin
                first_next = first_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            first_reg     <= 1'b1;
            duty_reg      <= '0;
            count_reg     <= '0;
            lost_reg      <= 1'b0;
            error_reg     <= 1'b0;
            wrong_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (commit)
            begin
                first_reg     <= first_next;
                duty_reg      <= duty_next;
                count_reg     <= count_next;
                lost_reg      <= lost_next;
                error_reg     <= error_next;
                wrong_reg     <= wrong_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_data;
        end
        if (commit)
        begin
            out_reg.duty        <= duty_next;
            out_reg.no_signal   <= lost_next;
            out_reg.math_error  <= error_next;
            out_reg.wrong_count <= wrong_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("Divider finished outside the divide state.");

    a_duty_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        duty_reg <= (DUTY_BITS'(1) << DUTY_FRACTION_BITS))
        else $error("Duty value exceeds full scale.");

    a_wrong_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        wrong_reg >= $past(wrong_reg))
        else $error("Invalid capture count decreased.");

    a_first_cleared_by_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(first_reg) |-> $past(commit && (item_reg.action == ACT_RISE)))
        else $error("First-edge flag cleared without a rising-edge item.");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(error_reg) |-> error_reg)
        else $error("Error flag cleared outside reset.");

endmodule
